// File: rtl/flvp_pkg.sv
// Shared types and constants for the FLV tag stream parser.
package flvp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } flvp_in_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [1:0]  stream_flags;
    logic [7:0]  tag_kind;
    logic [23:0] payload_length;
    logic [23:0] time_low;
    logic [7:0]  time_ext;
    logic [23:0] stream_number;
    logic [3:0]  codec_id;
    logic [3:0]  frame_or_rate;
    logic [1:0]  size_and_channels;
    logic        meta_ok;
    logic        last_of_run;
  } flvp_out_t;

  localparam logic [3:0] EV_HEADER_OK    = 4'd0;
  localparam logic [3:0] EV_TAG_DONE     = 4'd1;
  localparam logic [3:0] EV_END_OK       = 4'd2;
  localparam logic [3:0] EV_BAD_SIG      = 4'd3;
  localparam logic [3:0] EV_BAD_VERSION  = 4'd4;
  localparam logic [3:0] EV_BAD_FLAGS    = 4'd5;
  localparam logic [3:0] EV_BAD_OFFSET   = 4'd6;
  localparam logic [3:0] EV_SIZE_MISMATCH = 4'd7;
  localparam logic [3:0] EV_TRUNCATED    = 4'd8;

  localparam logic [7:0] KIND_AUDIO  = 8'h08;
  localparam logic [7:0] KIND_VIDEO  = 8'h09;
  localparam logic [7:0] KIND_SCRIPT = 8'h12;
  localparam logic [23:0] META_MIN_LENGTH = 24'd18;
  localparam logic [31:0] TAG_HEADER_BYTES = 32'd11;

  // Work passed from the byte parser to the result stage: up to two results.
  typedef struct packed {
    logic      two;
    flvp_out_t first;
    flvp_out_t second;
  } flvp_job_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = 2;

  function automatic logic [7:0] meta_byte(input logic [3:0] idx);
    logic [7:0] r;
    begin
      case (idx)
        4'd0: r = 8'h02;
        4'd1: r = 8'h00;
        4'd2: r = 8'h0A;
        4'd3: r = 8'h6F;
        4'd4: r = 8'h6E;
        4'd5: r = 8'h4D;
        4'd6: r = 8'h65;
        4'd7: r = 8'h74;
        4'd8: r = 8'h61;
        4'd9: r = 8'h44;
        4'd10: r = 8'h61;
        4'd11: r = 8'h74;
        4'd12: r = 8'h61;
        4'd13: r = 8'h08;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

endpackage

// File: rtl/flvp_front.sv
// Byte parser: walks the FLV header and tags and forms result jobs.
module flvp_front (
  input  logic               clk,
  input  logic               rst,
  input  flvp_pkg::flvp_in_t in_word,
  input  logic               take,
  output logic               job_valid,
  output flvp_pkg::flvp_job_t job
);
  import flvp_pkg::*;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_PREV    = 5'b00010,
    PH_TAGHDR  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_HALT    = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [23:0] pos, pos_next;
  logic [31:0] acc, acc_next;
  logic [31:0] exp_prev, exp_prev_next;
  logic [7:0]  kind, kind_next;
  logic [23:0] len, len_next;
  logic [23:0] tlow, tlow_next;
  logic [7:0]  text, text_next;
  logic [23:0] sid, sid_next;
  logic [7:0]  fpb, fpb_next;
  logic        mmatch, mmatch_next;

  logic [7:0] b;
  logic       eos;
  logic       halted_err;
  flvp_out_t  ev_a, ev_tag, ev_trunc;
  logic       emit_a;
  logic [7:0] tb;

  assign b = in_word.data_byte;
  assign eos = in_word.end_of_stream;

  always_comb begin
    ev_tag = '0;
    ev_tag.event_res = EV_TAG_DONE;
    ev_tag.tag_kind = kind_next;
    ev_tag.payload_length = len_next;
    ev_tag.time_low = tlow_next;
    ev_tag.time_ext = text_next;
    ev_tag.stream_number = sid_next;
    tb = fpb_next;
    if (len_next != '0 && kind_next == KIND_AUDIO) begin
      ev_tag.codec_id = tb[7:4];
      ev_tag.frame_or_rate = {2'b00, tb[3:2]};
      ev_tag.size_and_channels = tb[1:0];
    end else if (len_next != '0 && kind_next == KIND_VIDEO) begin
      ev_tag.codec_id = tb[3:0];
      ev_tag.frame_or_rate = tb[7:4];
    end
    if (kind_next == KIND_SCRIPT) begin
      ev_tag.meta_ok = mmatch_next && (len_next >= META_MIN_LENGTH);
    end
  end

  always_comb begin
    phase_next = phase;
    pos_next = pos;
    acc_next = acc;
    exp_prev_next = exp_prev;
    kind_next = kind;
    len_next = len;
    tlow_next = tlow;
    text_next = text;
    sid_next = sid;
    fpb_next = fpb;
    mmatch_next = mmatch;
    ev_a = '0;
    emit_a = 1'b0;
    halted_err = 1'b0;
    ev_trunc = '0;
    ev_trunc.event_res = EV_TRUNCATED;
    case (phase)
      PH_HEADER: begin
        pos_next = pos + 24'd1;
        if (pos < 24'd3) begin
          if ((pos == 24'd0 && b != 8'h46) || (pos == 24'd1 && b != 8'h4C) ||
              (pos == 24'd2 && b != 8'h56)) begin
            ev_a.event_res = EV_BAD_SIG;
            halted_err = 1'b1;
          end
        end else if (pos == 24'd3) begin
          if (b != 8'h01) begin
            ev_a.event_res = EV_BAD_VERSION;
            halted_err = 1'b1;
          end
        end else if (pos == 24'd4) begin
          if ((b & 8'hFA) != 8'h00) begin
            ev_a.event_res = EV_BAD_FLAGS;
            halted_err = 1'b1;
          end
          kind_next = b;
          acc_next = '0;
        end else begin
          acc_next = {acc[23:0], b};
          if (pos == 24'd8) begin
            if (acc_next != 32'd9) begin
              ev_a.event_res = EV_BAD_OFFSET;
              halted_err = 1'b1;
            end else begin
              ev_a.event_res = EV_HEADER_OK;
              ev_a.stream_flags = {kind[2], kind[0]};
              emit_a = 1'b1;
              kind_next = '0;
              phase_next = PH_PREV;
              pos_next = '0;
              acc_next = '0;
            end
          end
        end
      end
      PH_PREV: begin
        acc_next = {acc[23:0], b};
        if (pos == 24'd3) begin
          if (acc_next != exp_prev) begin
            ev_a.event_res = EV_SIZE_MISMATCH;
            halted_err = 1'b1;
          end else begin
            phase_next = PH_TAGHDR;
            pos_next = '0;
            if (eos) begin
              ev_a.event_res = EV_END_OK;
              emit_a = 1'b1;
              phase_next = PH_HALT;
            end
          end
        end else begin
          pos_next = pos + 24'd1;
        end
      end
      PH_TAGHDR: begin
        if (pos == 24'd0) begin
          kind_next = b;
          len_next = '0;
          tlow_next = '0;
          text_next = '0;
          sid_next = '0;
          fpb_next = '0;
          mmatch_next = 1'b1;
        end else if (pos <= 24'd3) begin
          len_next = {len[15:0], b};
        end else if (pos <= 24'd6) begin
          tlow_next = {tlow[15:0], b};
        end else if (pos == 24'd7) begin
          text_next = b;
        end else begin
          sid_next = {sid[15:0], b};
        end
        if (pos == 24'd10) begin
          pos_next = '0;
          if (len_next == '0) begin
            ev_a = ev_tag;
            emit_a = 1'b1;
            exp_prev_next = {8'd0, len_next} + TAG_HEADER_BYTES;
            phase_next = PH_PREV;
            acc_next = '0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          pos_next = pos + 24'd1;
        end
      end
      PH_PAYLOAD: begin
        if (pos == 24'd0) fpb_next = b;
        if (pos < 24'd14 && b != meta_byte(pos[3:0])) mmatch_next = 1'b0;
        if ({1'b0, pos} + 25'd1 >= {1'b0, len}) begin
          ev_a = ev_tag;
          emit_a = 1'b1;
          exp_prev_next = {8'd0, len} + TAG_HEADER_BYTES;
          phase_next = PH_PREV;
          pos_next = '0;
          acc_next = '0;
        end else begin
          pos_next = pos + 24'd1;
        end
      end
      default: ;
    endcase
    if (halted_err) begin
      phase_next = PH_HALT;
    end
    job = '0;
    job_valid = 1'b0;
    if (phase != PH_HALT) begin
      if (halted_err) begin
        job_valid = 1'b1;
        job.first = ev_a;
        job.first.last_of_run = 1'b1;
      end else if (emit_a && ev_a.event_res == EV_END_OK) begin
        job_valid = 1'b1;
        job.first = ev_a;
        job.first.last_of_run = 1'b1;
      end else if (eos) begin
        phase_next = PH_HALT;
        job_valid = 1'b1;
        if (emit_a) begin
          job.two = 1'b1;
          job.first = ev_a;
          job.second = ev_trunc;
          job.second.last_of_run = 1'b1;
        end else begin
          job.first = ev_trunc;
          job.first.last_of_run = 1'b1;
        end
      end else if (emit_a) begin
        job_valid = 1'b1;
        job.first = ev_a;
        job.first.last_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      pos <= '0;
      acc <= '0;
      exp_prev <= '0;
      kind <= '0;
      len <= '0;
      tlow <= '0;
      text <= '0;
      sid <= '0;
      fpb <= '0;
      mmatch <= 1'b1;
    end else if (take) begin
      phase <= phase_next;
      pos <= pos_next;
      acc <= acc_next;
      exp_prev <= exp_prev_next;
      kind <= kind_next;
      len <= len_next;
      tlow <= tlow_next;
      text <= text_next;
      sid <= sid_next;
      fpb <= fpb_next;
      mmatch <= mmatch_next;
    end
  end

endmodule

// File: rtl/flvp_back.sv
// Job queue and result sender: emits one or two result words per job.
module flvp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_push,
  input  flvp_pkg::flvp_job_t job,
  output logic                full,
  output logic                out_valid,
  output flvp_pkg::flvp_out_t out_word,
  input  logic                out_stall
);
  import flvp_pkg::*;

  flvp_job_t               q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wp, rp;
  logic [QUEUE_AW:0]       cnt;
  logic                    second_sel;
  logic                    pop;
  logic                    adv;
  flvp_job_t               head;

  assign head = q[rp];
  assign full = (cnt >= (QUEUE_AW+1)'(QUEUE_DEPTH - 1));
  assign out_valid = (cnt != '0);
  assign out_word = second_sel ? head.second : head.first;
  assign adv = out_valid && !out_stall;
  assign pop = adv && (second_sel || !head.two);

  always_ff @(posedge clk) begin
    if (job_push) q[wp] <= job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
      second_sel <= 1'b0;
    end else begin
      if (job_push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QUEUE_AW+1)'(job_push) - (QUEUE_AW+1)'(pop);
      if (adv) second_sel <= !pop;
    end
  end

endmodule

// File: rtl/flv_tag_stream_parser.sv
// Top level of the FLV tag stream parser.
// Input channel in_valid/in_stall carries one file byte per word plus an
// end-of-stream mark on the last byte. Output channel out_valid/out_stall
// carries result words: header ok, tag done, end ok or an error event.
// One byte is taken every cycle while the internal result queue has room;
// a byte that produces results has its first result visible the cycle after
// it is accepted if the queue held no earlier job, and a byte that produces
// two results sends them one after the other. Throughput is set by the output side: at most one result
// word per cycle leaves the four-entry job queue.
// Reset clears the parser to expect the file header and empties the queue.
// When the receiver stalls, results wait in the queue and in_stall rises
// once the queue is nearly full; no word is lost.
// After an error or end ok the parser ignores further bytes until reset.
module flv_tag_stream_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  flvp_pkg::flvp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output flvp_pkg::flvp_out_t out_data
);
  import flvp_pkg::*;

  logic      take, job_valid, full;
  flvp_job_t job;

  assign in_stall = full;
  assign take = in_valid && !full;

  flvp_front u_front (
    .clk(clk), .rst(rst), .in_word(in_data), .take(take),
    .job_valid(job_valid), .job(job)
  );

  flvp_back u_back (
    .clk(clk), .rst(rst), .job_push(take && job_valid), .job(job),
    .full(full), .out_valid(out_valid), .out_word(out_data),
    .out_stall(out_stall)
  );

endmodule

// File: tb/sv/tb_flv_tag_stream_parser.sv
// Self-checking testbench for the FLV tag stream parser: directed rows, then random streams.
module tb_flv_tag_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import flvp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BYTES = 1000;

  typedef enum logic [2:0] {PH_FILE_HDR, PH_PREV_SIZE, PH_TAG_HDR, PH_PAYLOAD, PH_HALTED}
    phase_t;

  typedef struct {
    logic [7:0] data;
    logic       eos;
    logic       typed;
    flvp_out_t  word;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  flvp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  flvp_out_t out_data;

  flv_tag_stream_parser dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser state as predicted.
  phase_t      ph = PH_FILE_HDR;
  logic [23:0] pos = '0;
  logic [31:0] acc = '0;
  logic [31:0] want_prev = '0;
  logic [7:0]  cur_kind = '0;
  logic [23:0] cur_len = '0;
  logic [23:0] cur_time = '0;
  logic [7:0]  cur_ext = '0;
  logic [23:0] cur_stream = '0;
  logic [7:0]  first_byte = '0;
  logic        meta_match = 1'b1;

  logic [7:0] meta_name [14] = '{8'h02, 8'h00, 8'h0A, "o", "n", "M", "e", "t", "a", "D",
                                 "a", "t", "a", 8'h08};
  logic [7:0] flv_sig [3] = '{"F", "L", "V"};

  flvp_out_t expected_words [$];
  flvp_out_t fresh [2];
  int fresh_n;
  int fails = 0;
  int cycles = 0;
  int bytes_sent = 0;

  function automatic flvp_out_t event_word(logic [3:0] ev, logic [1:0] flags);
    flvp_out_t w;
    w = '0;
    w.event_res = ev;
    w.stream_flags = flags;
    return w;
  endfunction

  task automatic add_word(flvp_out_t w);
    fresh[fresh_n] = w;
    fresh_n++;
  endtask

  task automatic halt_on(logic [3:0] ev);
    add_word(event_word(ev, 2'd0));
    ph = PH_HALTED;
  endtask

  task automatic finish_tag();
    flvp_out_t w;
    w = event_word(EV_TAG_DONE, 2'd0);
    w.tag_kind = cur_kind;
    w.payload_length = cur_len;
    w.time_low = cur_time;
    w.time_ext = cur_ext;
    w.stream_number = cur_stream;
    if (cur_len != 0 && cur_kind == KIND_AUDIO) begin
      w.codec_id = first_byte[7:4];
      w.frame_or_rate = {2'b00, first_byte[3:2]};
      w.size_and_channels = first_byte[1:0];
    end else if (cur_len != 0 && cur_kind == KIND_VIDEO) begin
      w.codec_id = first_byte[3:0];
      w.frame_or_rate = first_byte[7:4];
    end
    if (cur_kind == KIND_SCRIPT) w.meta_ok = meta_match && cur_len >= META_MIN_LENGTH;
    add_word(w);
    want_prev = {8'd0, cur_len} + TAG_HEADER_BYTES;
    ph = PH_PREV_SIZE;
    pos = '0;
    acc = '0;
  endtask

  // Works out the result words of one accepted byte into fresh[].
  task automatic predict_byte(logic [7:0] b, logic eos);
    logic stop;
    stop = 1'b0;
    fresh_n = 0;
    case (ph)
      PH_FILE_HDR: begin
        if (pos < 3) begin
          if (b != flv_sig[pos[1:0]]) begin halt_on(EV_BAD_SIG); stop = 1'b1; end
        end else if (pos == 3) begin
          if (b != 8'h01) begin halt_on(EV_BAD_VERSION); stop = 1'b1; end
        end else if (pos == 4) begin
          if ((b & 8'hFA) != 0) begin halt_on(EV_BAD_FLAGS); stop = 1'b1; end
          cur_kind = b;
          acc = '0;
        end else begin
          acc = {acc[23:0], b};
        end
        if (!stop && pos == 8) begin
          if (acc != 32'd9) begin
            halt_on(EV_BAD_OFFSET);
            stop = 1'b1;
          end else begin
            add_word(event_word(EV_HEADER_OK, {cur_kind[2], cur_kind[0]}));
            cur_kind = '0;
            ph = PH_PREV_SIZE;
            pos = '0;
            acc = '0;
          end
        end else if (!stop) begin
          pos = pos + 24'd1;
        end
      end
      PH_PREV_SIZE: begin
        acc = {acc[23:0], b};
        if (pos == 3) begin
          if (acc != want_prev) begin
            halt_on(EV_SIZE_MISMATCH);
            stop = 1'b1;
          end else if (eos) begin
            halt_on(EV_END_OK);
            stop = 1'b1;
          end else begin
            ph = PH_TAG_HDR;
            pos = '0;
          end
        end else begin
          pos = pos + 24'd1;
        end
      end
      PH_TAG_HDR: begin
        if (pos == 0) begin
          cur_kind = b;
          cur_len = '0;
          cur_time = '0;
          cur_ext = '0;
          cur_stream = '0;
          first_byte = '0;
          meta_match = 1'b1;
        end else if (pos <= 3) cur_len = {cur_len[15:0], b};
        else if (pos <= 6) cur_time = {cur_time[15:0], b};
        else if (pos == 7) cur_ext = b;
        else cur_stream = {cur_stream[15:0], b};
        if (pos == 10) begin
          pos = '0;
          if (cur_len == 0) finish_tag();
          else ph = PH_PAYLOAD;
        end else begin
          pos = pos + 24'd1;
        end
      end
      PH_PAYLOAD: begin
        if (pos == 0) first_byte = b;
        if (pos < 14 && b != meta_name[pos[3:0]]) meta_match = 1'b0;
        if (pos + 24'd1 >= cur_len) finish_tag();
        else pos = pos + 24'd1;
      end
      default: stop = 1'b1;
    endcase
    if (!stop && eos) halt_on(EV_TRUNCATED);
    if (fresh_n > 0) fresh[fresh_n - 1].last_of_run = 1'b1;
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0d: %s got %0h expected %0h", cycles, field, got, want);
    fails++;
  endtask

  task automatic check_word(flvp_out_t got, flvp_out_t want);
    if (got.event_res != want.event_res)
      report("event_res", 32'(got.event_res), 32'(want.event_res));
    if (got.stream_flags != want.stream_flags)
      report("stream_flags", 32'(got.stream_flags), 32'(want.stream_flags));
    if (got.tag_kind != want.tag_kind)
      report("tag_kind", 32'(got.tag_kind), 32'(want.tag_kind));
    if (got.payload_length != want.payload_length)
      report("payload_length", 32'(got.payload_length), 32'(want.payload_length));
    if (got.time_low != want.time_low)
      report("time_low", 32'(got.time_low), 32'(want.time_low));
    if (got.time_ext != want.time_ext)
      report("time_ext", 32'(got.time_ext), 32'(want.time_ext));
    if (got.stream_number != want.stream_number)
      report("stream_number", 32'(got.stream_number), 32'(want.stream_number));
    if (got.codec_id != want.codec_id)
      report("codec_id", 32'(got.codec_id), 32'(want.codec_id));
    if (got.frame_or_rate != want.frame_or_rate)
      report("frame_or_rate", 32'(got.frame_or_rate), 32'(want.frame_or_rate));
    if (got.size_and_channels != want.size_and_channels)
      report("size_and_channels", 32'(got.size_and_channels), 32'(want.size_and_channels));
    if (got.meta_ok != want.meta_ok)
      report("meta_ok", 32'(got.meta_ok), 32'(want.meta_ok));
    if (got.last_of_run != want.last_of_run)
      report("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0)
        report("unexpected word", 32'(out_data.event_res), 32'd0);
      else check_word(out_data, expected_words.pop_front());
    end
  end

  // Receiver: random hold-offs, calm stretches, and one long hold-off mid-run.
  initial begin : receiver
    int hold;
    logic calm;
    logic long_done;
    calm = 1'b0;
    long_done = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 40) == 0) calm = ~calm;
      hold = calm ? 0 : $urandom_range(0, 10);
      if (!long_done && bytes_sent > 300) begin
        hold = 400;
        long_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  logic sender_calm = 1'b0;

  // Offers one byte, waits for it to be taken, then predicts its results.
  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    if ($urandom_range(0, 50) == 0) sender_calm = ~sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, end_of_stream: eos};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic queue_fresh();
    for (int i = 0; i < fresh_n; i++) expected_words.push_back(fresh[i]);
  endtask

  task automatic send_prev(logic [31:0] value, logic eos, logic corrupt);
    if (corrupt) value = value ^ ($urandom_range(1, 255));
    for (int i = 3; i >= 0; i--) begin
      send_byte(value[8*i +: 8], eos && i == 0);
      queue_fresh();
    end
  endtask

  // Sends one tag; when cut_at is not negative, that byte carries the end mark.
  task automatic send_tag(int cut_at, output int length);
    logic [7:0] kind;
    logic [7:0] hdr [11];
    logic [23:0] t;
    logic [23:0] sid;
    logic meta;
    int n;
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: kind = KIND_AUDIO;
      1: kind = KIND_VIDEO;
      2: kind = KIND_SCRIPT;
      default: kind = 8'($urandom_range(0, 255));
    endcase
    meta = kind == KIND_SCRIPT && $urandom_range(0, 3) != 0;
    if ($urandom_range(0, 60) == 0) length = $urandom_range(200, 600);
    else if (meta) length = $urandom_range(14, 30);
    else length = $urandom_range(0, 24);
    t = {8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))};
    sid = {8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))};
    hdr = '{kind, length[23:16], length[15:8], length[7:0], t[23:16], t[15:8], t[7:0],
            8'($urandom_range(0, 255)), sid[23:16], sid[15:8], sid[7:0]};
    n = 0;
    for (int i = 0; i < 11; i++) begin
      if (cut_at >= 0 && n > cut_at) return;
      send_byte(hdr[i], n == cut_at);
      queue_fresh();
      n++;
    end
    for (int i = 0; i < length; i++) begin
      if (cut_at >= 0 && n > cut_at) return;
      b = 8'($urandom_range(0, 255));
      if (meta && i < 14) begin
        b = meta_name[i];
        if ($urandom_range(0, 15) == 0) b = b ^ (8'd1 << $urandom_range(0, 7));
      end
      send_byte(b, n == cut_at);
      queue_fresh();
      n++;
    end
  endtask

  dir_row_t dir_rows [$];

  initial begin : stimulus
    int len;
    int ending;
    dir_row_t r;
    // Header with both stream flags, an empty first previous size, then a
    // zero-length tag with every other header field at its top value.
    static logic [7:0] bytes [24] = '{"F", "L", "V", 8'h01, 8'h05, 8'h00, 8'h00, 8'h00,
                                      8'h09, 8'h00, 8'h00, 8'h00, 8'h00,
                                      8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                                      8'hFF, 8'hFF, 8'hFF, 8'hFF};
    for (int i = 0; i < 24; i++) begin
      r.data = bytes[i];
      r.eos = 1'b0;
      r.typed = 1'b0;
      r.word = '0;
      if (i == 8) begin
        r.typed = 1'b1;
        r.word = event_word(EV_HEADER_OK, 2'd3);
        r.word.last_of_run = 1'b1;
      end else if (i == 23) begin
        r.typed = 1'b1;
        r.word = '{event_res: EV_TAG_DONE, tag_kind: 8'hFF, payload_length: 24'd0,
                   time_low: 24'hFFFFFF, time_ext: 8'hFF, stream_number: 24'hFFFFFF,
                   last_of_run: 1'b1, default: '0};
      end
      dir_rows.push_back(r);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].eos);
      if (dir_rows[i].typed) expected_words.push_back(dir_rows[i].word);
      else queue_fresh();
    end

    len = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      send_prev(len + 11, 1'b0, 1'b0);
      send_tag(-1, len);
    end
    ending = $urandom_range(0, 2);
    case (ending)
      0: send_prev(len + 11, 1'b1, 1'b0);
      1: send_prev(len + 11, 1'($urandom_range(0, 1)), 1'b1);
      default: begin
        send_prev(len + 11, 1'b0, 1'b0);
        send_tag($urandom_range(0, 20), len);
      end
    endcase
    // Trailing words after the end; the predictor decides what they cause.
    repeat (5) begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      queue_fresh();
    end
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// File: files.f
rtl/flvp_pkg.sv
rtl/flvp_front.sv
rtl/flvp_back.sv
rtl/flv_tag_stream_parser.sv
tb/sv/tb_flv_tag_stream_parser.sv
